// ===== hdl/hmpgr_pkg.sv =====
// Shared types, codes and geometry constants for the hash map block.
// No dependencies; imported by the top module and the engine, not by hmpgr_ram.
`timescale 1ns / 1ps
`default_nettype none

package hmpgr_pkg;

  // Table geometry: bucket = key mod BUCKETS, WAYS slots per bucket.
  localparam int BKT_W   = 6;
  localparam int BUCKETS = 1 << BKT_W;
  localparam int WAY_W   = 2;
  localparam int WAYS    = 1 << WAY_W;
  localparam int SLOTS   = BUCKETS * WAYS;
  localparam int SLOT_AW = BKT_W + WAY_W;
  localparam int FILL_W  = $clog2(WAYS + 1);

  // Field widths.
  localparam int CMD_W   = 2;
  localparam int KEY_W   = 31;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int TOTAL_W = 9;

  // Stream packing.
  localparam int IN_BITS      = KEY_W + VAL_W;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int IN_TUSER_W   = CMD_W;
  localparam int OUT_BITS     = STAT_W + VAL_W + TOTAL_W + 1;
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUT    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_GET    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [VAL_W-1:0]   found_value;
    logic [TOTAL_W-1:0] entry_total;
    logic               is_empty;
  } res_t;

  // Engine handshake status toward the stream wrapper.
  typedef struct packed {
    logic idle;
    logic done;
  } eng_stat_t;

endpackage

`default_nettype wire

// ===== hdl/hash_map_put_get_remove.sv =====
// Sequence: put, a full bucket, an unused command or a get/remove on an empty bucket read
//   the bucket fill and post the result; get/remove otherwise read and compare the ways one
//   by one until a match, and remove then shifts each later entry down one slot. One command
//   is in work at a time: each way is read from the slot RAM before it is compared or moved.
// Handshake: the next input beat is taken in the cycle after the sequencer posts its result;
//   a result waits while the result register is full. Reset: synchronous active high,
//   input not ready during reset; bucket fill valid bits clear at once, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module hash_map_put_get_remove
  import hmpgr_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,

  // Command stream
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // tdata: key [30:0], value [62:31], zero pad above
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  // tuser: cmd [1:0]
  input  wire logic [IN_TUSER_W-1:0]  s_tuser,

  // Result stream
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // tdata: status [1:0], found_value [33:2], entry_total [42:34], is_empty [43], zero pad
  output logic [OUT_TDATA_W-1:0]      m_tdata
);

  req_t      req;
  res_t      res;
  eng_stat_t eng_stat;
  logic      start;
  logic      out_free;

  // Unpack the command beat.
  assign req.cmd   = s_tuser[CMD_W-1:0];
  assign req.key   = s_tdata[KEY_W-1:0];
  assign req.value = s_tdata[KEY_W+VAL_W-1:KEY_W];

  // Take a command only while the sequencer waits for one and reset is released.
  assign s_tready = eng_stat.idle && !rst;
  assign start    = s_tvalid && s_tready;

  // The result register may load when empty or draining this cycle.
  assign out_free = !m_tvalid || m_tready;

  hmpgr_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req      (req),
    .out_free (out_free),
    .stat     (eng_stat),
    .res      (res)
  );

  // Result register: hold the beat until the sink takes it, so the next
  // command can already start while it waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (eng_stat.done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_stat.done) begin
      m_tdata <= {(OUT_TDATA_W - OUT_BITS)'(0), res.is_empty, res.entry_total,
                  res.found_value, res.status};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hmpgr_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hmpgr_ram #(
  parameter int ADDR_W = 6,
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/hmpgr_engine.sv =====
// Command sequencer: bucket fill lookup, put append, way-by-way key compare, remove compaction.
// Depends on hmpgr_pkg and hmpgr_ram.
`timescale 1ns / 1ps
`default_nettype none

module hmpgr_engine
  import hmpgr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire req_t req,
  input  wire logic out_free,
  output eng_stat_t stat,
  output res_t      res
);

  state_t state, state_next;

  logic [CMD_W-1:0]   cmd_q;
  logic [KEY_W-1:0]   key_q;
  logic [VAL_W-1:0]   val_q;
  logic [BKT_W-1:0]   bucket_q;
  logic [FILL_W-1:0]  fill_q, fill_q_next;
  logic [WAY_W-1:0]   way_q, way_next;
  logic [STAT_W-1:0]  status_q, status_next;
  logic [VAL_W-1:0]   found_q, found_next;
  logic [TOTAL_W-1:0] count, count_next;
  logic [BUCKETS-1:0] bvalid;
  logic               bvalid_set;

  // Fill store
  logic              fill_we;
  logic [FILL_W-1:0] fill_wdata;
  logic [BKT_W-1:0]  fill_raddr;
  logic [FILL_W-1:0] fill_rdata;
  logic [FILL_W-1:0] fill_cur;

  // Slot store
  logic               slot_we;
  logic [SLOT_AW-1:0] slot_waddr;
  slot_t              slot_wdata;
  logic [SLOT_AW-1:0] slot_raddr;
  slot_t              slot_rdata;
  logic [WAY_W-1:0]   way_inc;
  logic [WAY_W-1:0]   rd_way;
  logic [FILL_W-1:0]  way_ext_inc;
  logic               key_hit;

  assign fill_raddr  = (state == S_IDLE) ? req.key[BKT_W-1:0] : bucket_q;
  assign fill_cur    = bvalid[bucket_q] ? fill_rdata : '0;
  assign way_inc     = way_q + WAY_W'(1);
  assign way_ext_inc = FILL_W'(way_q) + FILL_W'(1);
  assign rd_way      = (state == S_SHIFT_RD) ? way_inc : way_q;
  assign slot_raddr  = {bucket_q, rd_way};
  assign key_hit     = (slot_rdata.key == key_q);

  hmpgr_ram #(.ADDR_W(BKT_W), .DATA_W(FILL_W)) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (bucket_q),
    .wdata (fill_wdata),
    .raddr (fill_raddr),
    .rdata (fill_rdata)
  );

  hmpgr_ram #(.ADDR_W(SLOT_AW), .DATA_W($bits(slot_t))) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      bvalid <= '0;
    end else begin
      count <= count_next;
      if (bvalid_set) begin
        bvalid[bucket_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cmd_q    <= req.cmd;
      key_q    <= req.key;
      val_q    <= req.value;
      bucket_q <= req.key[BKT_W-1:0];
    end
    fill_q   <= fill_q_next;
    way_q    <= way_next;
    status_q <= status_next;
    found_q  <= found_next;
  end

  always_comb begin
    state_next  = state;
    fill_q_next = fill_q;
    way_next    = way_q;
    status_next = status_q;
    found_next  = found_q;
    count_next  = count;
    bvalid_set  = 1'b0;
    fill_we     = 1'b0;
    fill_wdata  = fill_q - FILL_W'(1);
    slot_we     = 1'b0;
    slot_waddr  = {bucket_q, way_q};
    slot_wdata  = slot_rdata;
    stat.idle   = 1'b0;
    stat.done   = 1'b0;

    case (state)
      S_IDLE: begin
        stat.idle = 1'b1;
        if (start) begin
          status_next = ST_NOT_FOUND;
          found_next  = '0;
          way_next    = '0;
          state_next  = S_FILL;
        end
      end

      S_FILL: begin
        fill_q_next = fill_cur;
        if (cmd_q == CMD_PUT) begin
          if (fill_cur >= FILL_W'(WAYS)) begin
            status_next = ST_FULL;
          end else begin
            // Append at the tail of the bucket.
            slot_we          = 1'b1;
            slot_waddr       = {bucket_q, fill_cur[WAY_W-1:0]};
            slot_wdata.key   = key_q;
            slot_wdata.value = val_q;
            fill_we          = 1'b1;
            fill_wdata       = fill_cur + FILL_W'(1);
            bvalid_set       = 1'b1;
            count_next       = count + TOTAL_W'(1);
            status_next      = ST_OK;
          end
          state_next = S_RESP;
        end else if ((cmd_q == CMD_GET || cmd_q == CMD_REMOVE) &&
                     fill_cur != '0) begin
          state_next = S_SCAN_RD;
        end else begin
          state_next = S_RESP;
        end
      end

      S_SCAN_RD: begin
        state_next = S_SCAN_CMP;
      end

      S_SCAN_CMP: begin
        if (key_hit) begin
          status_next = ST_OK;
          found_next  = slot_rdata.value;
          if (cmd_q == CMD_REMOVE) begin
            if (way_ext_inc < fill_q) begin
              state_next = S_SHIFT_RD;
            end else begin
              // Oldest match was the tail: just shrink the bucket.
              fill_we    = 1'b1;
              count_next = (count != '0) ? count - TOTAL_W'(1) : count;
              state_next = S_RESP;
            end
          end else begin
            state_next = S_RESP;
          end
        end else if (way_ext_inc < fill_q) begin
          way_next   = way_inc;
          state_next = S_SCAN_RD;
        end else begin
          state_next = S_RESP;
        end
      end

      S_SHIFT_RD: begin
        state_next = S_SHIFT_WR;
      end

      S_SHIFT_WR: begin
        // Move the later entry down one slot.
        slot_we  = 1'b1;
        way_next = way_inc;
        if (way_ext_inc < fill_q - FILL_W'(1)) begin
          state_next = S_SHIFT_RD;
        end else begin
          fill_we    = 1'b1;
          count_next = (count != '0) ? count - TOTAL_W'(1) : count;
          state_next = S_RESP;
        end
      end

      S_RESP: begin
        if (out_free) begin
          stat.done  = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign res.status      = status_q;
  assign res.found_value = found_q;
  assign res.entry_total = count;
  assign res.is_empty    = (count == '0);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= TOTAL_W'(SLOTS))
    else $error("entry count above table capacity");

  a_start_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    start |=> !stat.idle)
    else $error("engine idle right after accepting a command");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) |-> (fill_cur <= FILL_W'(WAYS)))
    else $error("bucket fill above way count");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN_CMP || state == S_SHIFT_WR) |-> (FILL_W'(way_q) < fill_q))
    else $error("way index past bucket fill");

  a_miss_zero_value: assert property (@(posedge clk) disable iff (rst)
    (stat.done && status_q != ST_OK) |-> (found_q == '0))
    else $error("nonzero value on a failed command");
`endif

endmodule

`default_nettype wire
